// File: hw/rtl/sdau_pkg.sv
`timescale 1ns / 1ps
package sdau_pkg;

  localparam logic [2:0] MODE_ADD     = 3'd0;
  localparam logic [2:0] MODE_SUB     = 3'd1;
  localparam logic [2:0] MODE_MUL     = 3'd2;
  localparam logic [2:0] MODE_DIV     = 3'd3;
  localparam logic [2:0] MODE_LESS    = 3'd4;
  localparam logic [2:0] MODE_EQUAL   = 3'd5;
  localparam logic [2:0] MODE_RESCALE = 3'd6;
  localparam logic [2:0] MODE_WHOLE   = 3'd7;

  // Quotient bits produced by the divider chain, one per cell
  localparam int DIV_BITS = 64;

  // Operation info that travels alongside the multipliers
  typedef struct packed {
    logic [2:0]  mode;
    logic [4:0]  places;
    logic [63:0] den;
    logic        dz;
    logic        use_div;
  } sdau_op_t;

  // Sideband that travels with each item through the divider cells
  typedef struct packed {
    logic [2:0]  mode;
    logic [4:0]  places;
    logic [63:0] value;
    logic        cmp;
    logic        dz;
    logic        neg;
    logic        use_div;
  } sdau_side_t;

  function automatic logic [63:0] pow10(input logic [4:0] k);
    logic [63:0] p;
    case (k)
      5'd0:    p = 64'd1;
      5'd1:    p = 64'd10;
      5'd2:    p = 64'd100;
      5'd3:    p = 64'd1000;
      5'd4:    p = 64'd10000;
      5'd5:    p = 64'd100000;
      5'd6:    p = 64'd1000000;
      5'd7:    p = 64'd10000000;
      5'd8:    p = 64'd100000000;
      5'd9:    p = 64'd1000000000;
      5'd10:   p = 64'd10000000000;
      5'd11:   p = 64'd100000000000;
      5'd12:   p = 64'd1000000000000;
      5'd13:   p = 64'd10000000000000;
      5'd14:   p = 64'd100000000000000;
      5'd15:   p = 64'd1000000000000000;
      5'd16:   p = 64'd10000000000000000;
      5'd17:   p = 64'd100000000000000000;
      5'd18:   p = 64'd1000000000000000000;
      default: p = 64'd1;
    endcase
    return p;
  endfunction

endpackage

// File: hw/rtl/sdau_mul.sv
`timescale 1ns / 1ps
// Low 64 bits of a 64x64 product, split into 32x32 partial products.
module sdau_mul import sdau_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [63:0] ll;
  logic [31:0] lh;
  logic [31:0] hl;
  logic [63:0] ll_c;
  logic [63:0] lh_c;
  logic [63:0] hl_c;

  always_comb begin
    ll_c = 64'(a[31:0]) * 64'(b[31:0]);
    lh_c = 64'(a[31:0]) * 64'(b[63:32]);
    hl_c = 64'(a[63:32]) * 64'(b[31:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ll <= ll_c;
      lh <= lh_c[31:0];
      hl <= hl_c[31:0];
      p  <= ll + {lh + hl, 32'd0};
    end
  end

endmodule

// File: hw/rtl/sdau_div_cell.sv
`timescale 1ns / 1ps
// One restoring-division step: shift, trial subtract, set quotient bit.
module sdau_div_cell import sdau_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                valid_in,
  input  logic [DIV_BITS-1:0] rem_in,
  input  logic [DIV_BITS-1:0] num_in,
  input  logic [DIV_BITS-1:0] den_in,
  input  sdau_side_t          side_in,
  output logic                valid_out,
  output logic [DIV_BITS-1:0] rem_out,
  output logic [DIV_BITS-1:0] num_out,
  output logic [DIV_BITS-1:0] den_out,
  output sdau_side_t          side_out
);

  logic [DIV_BITS-1:0] r_sh;
  logic [DIV_BITS:0]   trial;
  logic [DIV_BITS-1:0] rem_next;
  logic [DIV_BITS-1:0] num_next;

  always_comb begin
    r_sh     = {rem_in[DIV_BITS-2:0], num_in[DIV_BITS-1]};
    trial    = {1'b0, r_sh} - {1'b0, den_in};
    num_next = {num_in[DIV_BITS-2:0], ~trial[DIV_BITS]};
    rem_next = trial[DIV_BITS] ? r_sh : trial[DIV_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= rem_next;
      num_out  <= num_next;
      den_out  <= den_in;
      side_out <= side_in;
    end
  end

endmodule

// File: hw/rtl/scaled_decimal_arithmetic_unit_top.sv
`timescale 1ns / 1ps
// Scaled decimal arithmetic unit.
// Input channel (in_valid/in_ready) carries one operation: mode, operands
// a and b with their decimal place counts, and a target place count.
// Output channel (out_valid/out_ready) returns one result per operation:
// result_value, result_places, compare_true and divide_by_zero.
// Every operation takes the same path from input transfer to output valid:
// an operand setup register, the split 32x32 multipliers (partial-product
// and sum registers), an add/compare register, 64 divider cells (one
// quotient bit each) and one output register. Results leave in input order.
// Throughput is one operation per cycle while the output is not stalled.
// When the receiver stalls, the whole pipe holds and in_ready drops until
// the waiting result is taken.
// Reset clears all valid bits; no result is pending after reset.
module scaled_decimal_arithmetic_unit_top import sdau_pkg::*; #(
  parameter int MAX_PLACES = 9,
  parameter int VALUE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [63:0] a_value,
  input  logic [3:0]  a_places,
  input  logic [63:0] b_value,
  input  logic [3:0]  b_places,
  input  logic [3:0]  target_places,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] result_value,
  output logic [4:0]  result_places,
  output logic        compare_true,
  output logic        divide_by_zero
);

  localparam int         WRAP_SH = 64 - VALUE_BITS;
  localparam logic [4:0] MAXP    = 5'(MAX_PLACES);

  function automatic logic [63:0] wrapv(input logic [63:0] x);
    logic [63:0] s;
    s = x << WRAP_SH;
    return 64'($signed(s) >>> WRAP_SH);
  endfunction

  function automatic logic [4:0] clampp(input logic [3:0] x);
    return ({1'b0, x} > MAXP) ? MAXP : {1'b0, x};
  endfunction

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Operand setup
  logic [4:0]  ap, bp, tp, pm;
  logic [63:0] av, bv;
  logic [63:0] x1_c, x2_c;
  sdau_op_t    op_c;

  always_comb begin
    ap = clampp(a_places);
    bp = clampp(b_places);
    tp = clampp(target_places);
    pm = (ap > bp) ? ap : bp;
    av = wrapv(a_value);
    bv = wrapv(b_value);
    x1_c = 64'd1;
    x2_c = 64'd1;
    op_c.mode    = mode;
    op_c.places  = 5'd0;
    op_c.den     = 64'd1;
    op_c.dz      = 1'b0;
    op_c.use_div = 1'b0;
    case (mode) inside
      MODE_ADD, MODE_SUB, MODE_LESS, MODE_EQUAL: begin
        x1_c = pow10(pm - ap);
        x2_c = pow10(pm - bp);
        if (mode == MODE_ADD || mode == MODE_SUB) begin
          op_c.places = pm;
        end
      end
      MODE_MUL: begin
        x1_c = bv;
        op_c.places = 5'(ap + bp);
      end
      MODE_DIV: begin
        x1_c = pow10(bp);
        op_c.places  = ap;
        op_c.den     = bv;
        op_c.dz      = (bv == 64'd0);
        op_c.use_div = 1'b1;
      end
      MODE_RESCALE: begin
        op_c.places = tp;
        if (tp < ap) begin
          op_c.den     = pow10(ap - tp);
          op_c.use_div = 1'b1;
        end else begin
          x1_c = pow10(tp - ap);
        end
      end
      default: begin
        op_c.den     = pow10(ap);
        op_c.use_div = 1'b1;
      end
    endcase
  end

  logic        v_a;
  logic [63:0] av_a, bv_a, x1_a, x2_a;
  sdau_op_t    op_a;

  always_ff @(posedge clk) begin
    if (en) begin
      av_a <= av;
      bv_a <= bv;
      x1_a <= x1_c;
      x2_a <= x2_c;
      op_a <= op_c;
    end
  end

  // Multipliers
  logic [63:0] prod1, prod2;

  sdau_mul u_mul1 (.clk(clk), .en(en), .a(av_a), .b(x1_a), .p(prod1));
  sdau_mul u_mul2 (.clk(clk), .en(en), .a(bv_a), .b(x2_a), .p(prod2));

  logic [1:0] v_m;
  sdau_op_t   op_m1, op_m2;

  always_ff @(posedge clk) begin
    if (en) begin
      op_m1 <= op_a;
      op_m2 <= op_m1;
    end
  end

  // Add, compare and divider setup
  logic [63:0] m1, m2;
  logic [63:0] mn, md;
  sdau_side_t  side_c;

  always_comb begin
    m1 = wrapv(prod1);
    m2 = wrapv(prod2);
    mn = m1[63] ? 64'd0 - m1 : m1;
    md = op_m2.den[63] ? 64'd0 - op_m2.den : op_m2.den;
    side_c.mode    = op_m2.mode;
    side_c.places  = op_m2.places;
    side_c.value   = m1;
    side_c.cmp     = 1'b0;
    side_c.dz      = op_m2.dz;
    side_c.neg     = m1[63] ^ op_m2.den[63];
    side_c.use_div = op_m2.use_div;
    case (op_m2.mode)
      MODE_ADD:   side_c.value = wrapv(m1 + m2);
      MODE_SUB:   side_c.value = wrapv(m1 - m2);
      MODE_LESS: begin
        side_c.value = 64'd0;
        side_c.cmp   = $signed(m1) < $signed(m2);
      end
      MODE_EQUAL: begin
        side_c.value = 64'd0;
        side_c.cmp   = (m1 == m2);
      end
      default:    side_c.value = m1;
    endcase
  end

  logic                v_d;
  logic [DIV_BITS-1:0] num_d, den_d;
  sdau_side_t          side_d;

  always_ff @(posedge clk) begin
    if (en) begin
      num_d  <= mn;
      den_d  <= md;
      side_d <= side_c;
    end
  end

  // Divider chain
  logic                v_ch   [0:DIV_BITS];
  logic [DIV_BITS-1:0] rem_ch [0:DIV_BITS];
  logic [DIV_BITS-1:0] num_ch [0:DIV_BITS];
  logic [DIV_BITS-1:0] den_ch [0:DIV_BITS];
  sdau_side_t          side_ch[0:DIV_BITS];

  assign v_ch[0]    = v_d;
  assign rem_ch[0]  = '0;
  assign num_ch[0]  = num_d;
  assign den_ch[0]  = den_d;
  assign side_ch[0] = side_d;

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_cell
    sdau_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .valid_in (v_ch[i]),
      .rem_in   (rem_ch[i]),
      .num_in   (num_ch[i]),
      .den_in   (den_ch[i]),
      .side_in  (side_ch[i]),
      .valid_out(v_ch[i+1]),
      .rem_out  (rem_ch[i+1]),
      .num_out  (num_ch[i+1]),
      .den_out  (den_ch[i+1]),
      .side_out (side_ch[i+1])
    );
  end

  // Result select
  sdau_side_t  side_e;
  logic [63:0] quot;
  logic [63:0] val_c;

  always_comb begin
    side_e = side_ch[DIV_BITS];
    quot   = side_e.neg ? 64'd0 - num_ch[DIV_BITS] : num_ch[DIV_BITS];
    val_c  = side_e.value;
    if (side_e.use_div) begin
      if (side_e.mode == MODE_WHOLE) begin
        val_c = {{32{quot[31]}}, quot[31:0]};
      end else if (side_e.dz) begin
        val_c = 64'd0;
      end else begin
        val_c = wrapv(quot);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a       <= 1'b0;
      v_m       <= 2'b00;
      v_d       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_a       <= in_valid;
      v_m       <= {v_m[0], v_a};
      v_d       <= v_m[1];
      out_valid <= v_ch[DIV_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_value   <= val_c;
      result_places  <= side_e.places;
      compare_true   <= side_e.cmp;
      divide_by_zero <= side_e.dz;
    end
  end

endmodule

// File: hw/rtl/sdau_checker.sv
`timescale 1ns / 1ps
module sdau_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] result_value,
  input logic [4:0]  result_places,
  input logic        compare_true,
  input logic        divide_by_zero
);

  // A stalled result holds until transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value))
    else $error("output dropped or changed while stalled");

  // Input backpressure only comes from an output stall
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without output stall");

  a_cmp_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && compare_true |-> result_value == 64'd0 && result_places == 5'd0
      && !divide_by_zero)
    else $error("compare result carries a value");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> result_value == 64'd0 && !compare_true)
    else $error("zero divisor result not zero");

endmodule

bind scaled_decimal_arithmetic_unit_top sdau_checker u_sdau_checker (.*);

// File: dv/tb_scaled_decimal_arithmetic_unit_top.sv
`timescale 1ns / 1ps
module tb_scaled_decimal_arithmetic_unit_top;
  import sdau_pkg::*;

  localparam int MAX_PL = 9;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_RANDOM = 650;

  typedef struct packed {
    logic [63:0] value;
    logic [4:0]  places;
    logic        cmp;
    logic        dz;
  } dec_result_t;

  typedef struct {
    logic [2:0]  mode;
    logic [63:0] a;
    logic [3:0]  ap;
    logic [63:0] b;
    logic [3:0]  bp;
    logic [3:0]  tp;
    bit          typed;
    dec_result_t want;
  } dec_op_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  mode;
  logic [63:0] a_value;
  logic [3:0]  a_places;
  logic [63:0] b_value;
  logic [3:0]  b_places;
  logic [3:0]  target_places;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] result_value;
  logic [4:0]  result_places;
  logic        compare_true;
  logic        divide_by_zero;

  scaled_decimal_arithmetic_unit_top u_dut (.*);

  dec_result_t pending_results[$];
  dec_op_t     op_table[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  bit          quiet_phase = 0;
  bit          stim_done = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] ten_to(int k);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < k; i++) p = p * 64'd10;
    return p;
  endfunction

  function automatic logic [3:0] sat_places(logic [3:0] p);
    return (p > MAX_PL) ? 4'(MAX_PL) : p;
  endfunction

  // truncating signed division; divisor nonzero
  function automatic logic [63:0] trunc_div(logic [63:0] n, logic [63:0] d);
    logic [63:0] mn, md, q;
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    q = mn / md;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic dec_result_t decimal_op(dec_op_t op);
    dec_result_t r;
    logic [3:0]  ap, bp, tp, pm;
    logic [63:0] aa, ba, q;
    ap = sat_places(op.ap);
    bp = sat_places(op.bp);
    tp = sat_places(op.tp);
    pm = (ap > bp) ? ap : bp;
    aa = op.a * ten_to(pm - ap);
    ba = op.b * ten_to(pm - bp);
    r = '0;
    case (op.mode)
      MODE_ADD: begin
        r.value = aa + ba;
        r.places = 5'(pm);
      end
      MODE_SUB: begin
        r.value = aa - ba;
        r.places = 5'(pm);
      end
      MODE_MUL: begin
        r.value = op.a * op.b;
        r.places = 5'(ap) + 5'(bp);
      end
      MODE_DIV: begin
        r.places = 5'(ap);
        if (op.b == 0) r.dz = 1;
        else r.value = trunc_div(op.a * ten_to(bp), op.b);
      end
      MODE_LESS: r.cmp = ($signed(aa) < $signed(ba));
      MODE_EQUAL: r.cmp = (aa == ba);
      MODE_RESCALE: begin
        r.places = 5'(tp);
        if (tp < ap) r.value = trunc_div(op.a, ten_to(ap - tp));
        else r.value = op.a * ten_to(tp - ap);
      end
      default: begin
        q = trunc_div(op.a, ten_to(ap));
        r.value = {{32{q[31]}}, q[31:0]};
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 5))
      0: return {$urandom(), $urandom()};
      1: return 64'($signed($urandom_range(0, 2000)) - 1000);
      2: return {64{1'b1}} << $urandom_range(0, 63);
      3: return 64'd1 << $urandom_range(0, 63);
      default: return 64'($signed($urandom()) >>> $urandom_range(0, 20));
    endcase
  endfunction

  function automatic logic [3:0] rand_places();
    return ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
  endfunction

  task automatic add_row(logic [2:0] m, logic [63:0] a, logic [3:0] ap, logic [63:0] b,
                         logic [3:0] bp, logic [3:0] tp, bit typed = 0,
                         dec_result_t want = '0);
    dec_op_t op;
    op.mode = m; op.a = a; op.ap = ap; op.b = b; op.bp = bp; op.tp = tp;
    op.typed = typed; op.want = want;
    op_table.push_back(op);
  endtask

  initial begin
    dec_op_t op;
    logic [63:0] minv, maxv;
    minv = 64'h8000_0000_0000_0000;
    maxv = 64'h7fff_ffff_ffff_ffff;
    rst = 1;
    in_valid = 0;
    mode = MODE_ADD;
    a_value = '0; a_places = '0; b_value = '0; b_places = '0; target_places = '0;

    add_row(MODE_ADD, 64'd0, 0, 64'd5, 3, 0, 1, '{64'd5, 5'd3, 1'b0, 1'b0});
    add_row(MODE_ADD, 64'd7, 2, 64'd0, 0, 0, 1, '{64'd7, 5'd2, 1'b0, 1'b0});
    add_row(MODE_SUB, minv, 0, 64'd1, 0, 0, 1, '{maxv, 5'd0, 1'b0, 1'b0});
    add_row(MODE_ADD, maxv, 9, maxv, 0, 0);
    add_row(MODE_MUL, maxv, 15, minv, 15, 0, 1, '{minv, 5'd18, 1'b0, 1'b0});
    add_row(MODE_MUL, 64'd3, 9, 64'd4, 9, 0, 1, '{64'd12, 5'd18, 1'b0, 1'b0});
    add_row(MODE_DIV, 64'd123, 2, 64'd0, 0, 0, 1, '{64'd0, 5'd2, 1'b0, 1'b1});
    add_row(MODE_DIV, minv, 0, {64{1'b1}}, 0, 0, 1, '{minv, 5'd0, 1'b0, 1'b0});
    add_row(MODE_DIV, -64'sd7, 1, 64'd2, 0, 0, 1, '{-64'sd3, 5'd1, 1'b0, 1'b0});
    add_row(MODE_DIV, 64'd100, 3, -64'sd3, 12, 0);
    add_row(MODE_LESS, minv, 0, maxv, 0, 0, 1, '{64'd0, 5'd0, 1'b1, 1'b0});
    add_row(MODE_LESS, 64'd10, 1, 64'd1, 0, 0, 1, '{64'd0, 5'd0, 1'b0, 1'b0});
    add_row(MODE_EQUAL, 64'd10, 1, 64'd1, 0, 0, 1, '{64'd0, 5'd0, 1'b1, 1'b0});
    add_row(MODE_EQUAL, 64'd0, 0, 64'd0, 9, 0, 1, '{64'd0, 5'd0, 1'b1, 1'b0});
    add_row(MODE_RESCALE, -64'sd12345, 3, 0, 0, 1, 1, '{-64'sd123, 5'd1, 1'b0, 1'b0});
    add_row(MODE_RESCALE, 64'd5, 0, 0, 0, 15, 1, '{64'd5000000000, 5'd9, 1'b0, 1'b0});
    add_row(MODE_RESCALE, maxv, 4, 0, 0, 4, 1, '{maxv, 5'd4, 1'b0, 1'b0});
    add_row(MODE_WHOLE, -64'sd2500, 3, 0, 0, 0, 1, '{-64'sd2, 5'd0, 1'b0, 1'b0});
    add_row(MODE_WHOLE, maxv, 0, 0, 0, 0, 1, '{{64{1'b1}}, 5'd0, 1'b0, 1'b0});
    add_row(MODE_WHOLE, minv, 15, maxv, 15, 15);
    add_row(MODE_ADD, maxv, 15, minv, 15, 15);

    for (int i = 0; i < N_RANDOM; i++) begin
      add_row(3'($urandom_range(0, 7)), rand64(), rand_places(),
              ($urandom_range(0, 15) == 0) ? 64'd0 : rand64(), rand_places(), rand_places());
    end

    repeat (4) @(posedge clk);
    rst <= 0;

    foreach (op_table[i]) begin
      op = op_table[i];
      quiet_phase = (i >= 200 && i < 300);
      while (!quiet_phase && $urandom_range(0, 99) < 24) begin
        in_valid <= 0;
        @(posedge clk);
      end
      in_valid <= 1;
      mode <= op.mode;
      a_value <= op.a; a_places <= op.ap;
      b_value <= op.b; b_places <= op.bp;
      target_places <= op.tp;
      pending_results.push_back(op.typed ? op.want : decimal_op(op));
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid <= 0;
    stim_done = 1;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else begin
      out_ready <= quiet_phase || ($urandom_range(0, 99) >= 24);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected transfer", result_value, 0);
        end else begin
          dec_result_t w;
          w = pending_results.pop_front();
          if (result_value !== w.value) report_mismatch("result_value", result_value, w.value);
          if (result_places !== w.places)
            report_mismatch("result_places", 64'(result_places), 64'(w.places));
          if (compare_true !== w.cmp)
            report_mismatch("compare_true", 64'(compare_true), 64'(w.cmp));
          if (divide_by_zero !== w.dz)
            report_mismatch("divide_by_zero", 64'(divide_by_zero), 64'(w.dz));
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending_results.size() != 0 && cycle_count < CYCLE_LIMIT) @(posedge clk);
    repeat (100) @(posedge clk);
    if (pending_results.size() != 0) mismatch_count++;
    if (mismatch_count == 0) $display("scaled_decimal_arithmetic_unit_top regression: pass");
    else $display("scaled_decimal_arithmetic_unit_top regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("scaled_decimal_arithmetic_unit_top regression: fail");
      $finish;
    end
  end

endmodule

// File: scaled_decimal_arithmetic_unit_top.f
hw/rtl/sdau_pkg.sv
hw/rtl/sdau_mul.sv
hw/rtl/sdau_div_cell.sv
hw/rtl/scaled_decimal_arithmetic_unit_top.sv
hw/rtl/sdau_checker.sv
dv/tb_scaled_decimal_arithmetic_unit_top.sv
